>>> rtl/core/u8vd_pkg.sv
`default_nettype none

package u8vd_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] F4_LEAD_BITS   = 21'd4;

  localparam logic [7:0] BYTE_ASCII_LIMIT = 8'h80;
  localparam logic [7:0] BYTE_FIRST_BAD   = 8'hF5;
  localparam logic [7:0] BYTE_C1          = 8'hC1;
  localparam logic [7:0] BYTE_LEAD4       = 8'hF0;
  localparam logic [7:0] BYTE_LEAD3       = 8'hE0;
  localparam logic [7:0] BYTE_MIN_AFTER_E0 = 8'hA0;
  localparam logic [7:0] BYTE_F4_LIMIT    = 8'h90;
  localparam logic [7:0] BYTE_CONT_ZERO   = 8'h80;

  localparam logic [7:0] MASK_LEAD4 = 8'b0000_0111;
  localparam logic [7:0] MASK_LEAD3 = 8'b0000_1111;
  localparam logic [7:0] MASK_LEAD2 = 8'b0001_1111;
  localparam logic [7:0] MASK_ASCII = 8'b0111_1111;

  localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
  localparam logic [CNT_W-1:0] LEN_1    = 3'd1;
  localparam logic [CNT_W-1:0] LEN_2    = 3'd2;
  localparam logic [CNT_W-1:0] LEN_3    = 3'd3;
  localparam logic [CNT_W-1:0] LEN_4    = 3'd4;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [CP_W-1:0]  partial_value;
    logic [CNT_W-1:0] expected_bytes;
    logic [CNT_W-1:0] bytes_seen;
  } dec_state_t;

  // One result beat.
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] byte_count;
    logic             is_error;
    logic             last_of_run;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/utf8_validating_decoder_unit.sv
`default_nettype none

// UTF-8 decoder with validation. Each input beat carries one byte of the
// stream; each output beat carries one decoded code point, or U+FFFD with
// is_error set, together with the number of input bytes it covers and a
// last_of_run flag marking the final result caused by the byte just taken.
// A byte gives zero, one or two results. It gives zero when it only opens or
// extends a sequence and stream_end is clear. It gives two when it breaks an
// open sequence and then either is decoded on its own or, with stream_end
// set, opens a new sequence that is flushed at once. The
// pair C0 80 decodes to U+0000 and surrogate values are passed through.
// Bytes are taken at one per cycle. The decode of a byte is a single layer
// of combinational logic that reads the held sequence state and writes both
// the next state and up to two results into a four-entry result queue; the
// input stalls whenever that queue holds three or more results, so the
// sustained rate is one byte per cycle as long as the output side takes one
// result per cycle, and a byte that yields two results costs two output
// beats. A result can appear on the output in the cycle after its byte is
// taken.
module utf8_validating_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          stream_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u8vd_pkg::CP_W-1:0]     code_point,
  output logic [u8vd_pkg::CNT_W-1:0]    byte_count,
  output logic                          is_error,
  output logic                          last_of_run
);
  import u8vd_pkg::*;

  dec_state_t state;
  dec_state_t state_next;
  result_t    slot0;
  result_t    slot1;
  result_t    head;
  logic [1:0] num_results;
  logic [1:0] push_n;
  logic       has_room;
  logic       head_valid;
  logic       in_accept;
  logic       out_accept;

  assign in_stall   = !has_room;
  assign in_accept  = in_valid && has_room;
  assign out_valid  = head_valid;
  assign out_accept = head_valid && !out_stall;
  assign push_n     = in_accept ? num_results : 2'd0;

  // The sequence state only advances on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  u8vd_decode u_decode (
    .state       (state),
    .data_byte   (data_byte),
    .stream_end  (stream_end),
    .state_next  (state_next),
    .slot0       (slot0),
    .slot1       (slot1),
    .num_results (num_results)
  );

  u8vd_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .push0      (slot0),
    .push1      (slot1),
    .has_room   (has_room),
    .head_valid (head_valid),
    .pop        (out_accept),
    .head       (head)
  );

  assign code_point  = head.code_point;
  assign byte_count  = head.byte_count;
  assign is_error    = head.is_error;
  assign last_of_run = head.last_of_run;

  // After a beat marked as stream end, no sequence may remain open.
  a_end_flushes : assert property (@(posedge clk) disable iff (rst)
    (in_accept && stream_end) |=> (state.bytes_seen == state.expected_bytes))
    else $error("sequence still open after stream end");

  // Every error result carries the replacement character.
  a_error_cp : assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_error) |-> (code_point == REPLACEMENT_CP))
    else $error("error result without replacement code point");

  // A result always covers between one and four bytes.
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((byte_count >= LEN_1) && (byte_count <= LEN_4)))
    else $error("result byte count out of range");

endmodule

`default_nettype wire

>>> rtl/core/u8vd_decode.sv
`default_nettype none

module u8vd_decode (
  input  u8vd_pkg::dec_state_t state,
  input  logic [7:0]           data_byte,
  input  logic                 stream_end,
  output u8vd_pkg::dec_state_t state_next,
  output u8vd_pkg::result_t    slot0,
  output u8vd_pkg::result_t    slot1,
  output logic [1:0]           num_results
);
  import u8vd_pkg::*;

  // Three possible sources of a result: closing the open sequence, the byte
  // handled fresh, and the end-of-stream flush. At most two fire per byte.
  result_t    res_seq;
  result_t    res_fresh;
  result_t    res_flush;
  logic       v_seq;
  logic       v_fresh;
  logic       v_flush;
  logic       is_open;
  logic       is_cont;
  logic       bad;
  logic       handled;
  logic [CNT_W-1:0] seen_inc;
  logic [CP_W-1:0]  pv_shift;
  dec_state_t st;

  always_comb begin
    is_open   = (state.bytes_seen != state.expected_bytes);
    is_cont   = (data_byte[7:6] == 2'b10);
    st        = state;
    handled   = 1'b0;
    bad       = 1'b0;
    v_seq     = 1'b0;
    v_fresh   = 1'b0;
    v_flush   = 1'b0;
    res_seq   = '0;
    res_fresh = '0;
    res_flush = '0;
    seen_inc  = state.bytes_seen + LEN_1;
    pv_shift  = {state.partial_value[CP_W-7:0], data_byte[5:0]};

    if (is_open) begin
      bad = !is_cont;
      if (!bad && (state.bytes_seen == LEN_1)) begin
        if ((state.expected_bytes == LEN_4) && (state.partial_value == F4_LEAD_BITS) &&
            (data_byte >= BYTE_F4_LIMIT)) begin
          bad = 1'b1;
        end
        if (state.partial_value == '0) begin
          if ((state.expected_bytes == LEN_3) && (data_byte < BYTE_MIN_AFTER_E0)) bad = 1'b1;
          if ((state.expected_bytes == LEN_4) && (data_byte < BYTE_F4_LIMIT)) bad = 1'b1;
          if ((state.expected_bytes == LEN_2) && (data_byte != BYTE_CONT_ZERO)) bad = 1'b1;
        end
      end
      if (bad) begin
        v_seq   = 1'b1;
        res_seq = '{code_point: REPLACEMENT_CP, byte_count: state.bytes_seen,
                    is_error: 1'b1, last_of_run: 1'b0};
        st      = '0;
      end else begin
        handled = 1'b1;
        if (seen_inc == state.expected_bytes) begin
          v_seq   = 1'b1;
          res_seq = '{code_point: pv_shift, byte_count: seen_inc,
                      is_error: 1'b0, last_of_run: 1'b0};
          st      = '0;
        end else begin
          st.partial_value = pv_shift;
          st.bytes_seen    = seen_inc;
        end
      end
    end

    if (!handled) begin
      if (data_byte < BYTE_ASCII_LIMIT) begin
        v_fresh   = 1'b1;
        res_fresh = '{code_point: {{(CP_W-8){1'b0}}, data_byte & MASK_ASCII},
                      byte_count: LEN_1, is_error: 1'b0, last_of_run: 1'b0};
      end else if ((data_byte >= BYTE_FIRST_BAD) || (data_byte == BYTE_C1) || is_cont) begin
        v_fresh   = 1'b1;
        res_fresh = '{code_point: REPLACEMENT_CP, byte_count: LEN_1,
                      is_error: 1'b1, last_of_run: 1'b0};
      end else if (data_byte >= BYTE_LEAD4) begin
        st = '{partial_value: {{(CP_W-8){1'b0}}, data_byte & MASK_LEAD4},
               expected_bytes: LEN_4, bytes_seen: LEN_1};
      end else if (data_byte >= BYTE_LEAD3) begin
        st = '{partial_value: {{(CP_W-8){1'b0}}, data_byte & MASK_LEAD3},
               expected_bytes: LEN_3, bytes_seen: LEN_1};
      end else begin
        st = '{partial_value: {{(CP_W-8){1'b0}}, data_byte & MASK_LEAD2},
               expected_bytes: LEN_2, bytes_seen: LEN_1};
      end
    end

    if (stream_end && (st.bytes_seen != st.expected_bytes)) begin
      v_flush   = 1'b1;
      res_flush = '{code_point: REPLACEMENT_CP, byte_count: st.bytes_seen,
                    is_error: 1'b1, last_of_run: 1'b0};
      st        = '0;
    end

    state_next = st;

    // Pack the valid results into the low slots, in order.
    slot0 = v_seq ? res_seq : (v_fresh ? res_fresh : res_flush);
    slot1 = (v_seq && v_fresh) ? res_fresh : res_flush;
    num_results = {1'b0, v_seq} + {1'b0, v_fresh} + {1'b0, v_flush};
    slot0.last_of_run = (num_results == 2'd1);
    slot1.last_of_run = 1'b1;
  end

endmodule

`default_nettype wire

>>> rtl/core/u8vd_result_fifo.sv
`default_nettype none

module u8vd_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  u8vd_pkg::result_t push0,
  input  u8vd_pkg::result_t push1,
  output logic              has_room,
  output logic              head_valid,
  input  logic              pop,
  output u8vd_pkg::result_t head
);
  import u8vd_pkg::*;

  result_t           entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic [QPTR_W-1:0] wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + QPTR_W'(1);
  assign count_next   = count + QCNT_W'(push_n) - QCNT_W'(pop);

  // Room for two beats is needed before a byte is taken, since one byte can
  // produce two results.
  assign has_room   = (count <= QCNT_W'(QDEPTH - 2));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entries[wr_ptr] <= push0;
    if (push_n == 2'd2) entries[wr_ptr_plus1] <= push1;
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue count beyond depth");

  a_push_room : assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> has_room)
    else $error("result queue written without room");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("result queue read while empty");

endmodule

`default_nettype wire
